[hw/rtl/vgpc_pkg.sv]
// Package for the visibility graph property checker.
// Holds the payload structs, command codes and controller/datapath handshake structs.
// No dependencies.
`default_nettype none

package vgpc_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned IdxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned BarGap      = 3;
  localparam logic [CntW-1:0] VertexCountReset = CntW'(MaxVertices);

  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdRead  = 2'd1,
    CmdFix   = 2'd2,
    CmdPath  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    AddrRow  = 2'd0,
    AddrLast = 2'd1,
    AddrI    = 2'd2,
    AddrJ    = 2'd3
  } addr_sel_e;

  typedef struct packed {
    cmd_e            command;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] column;
    logic            bit_value;
  } in_t;

  typedef struct packed {
    logic read_bit;
    logic bar_ok;
  } out_t;

  typedef struct packed {
    logic      capture;
    logic      rd_en;
    addr_sel_e rd_sel;
    logic      rmw;
    logic      path_wr;
    logic      last_use;
    logic      mark_use;
    logic      last_wr;
    logic      rowi_use;
    logic      rowj_use;
    logic      out_load;
  } ctrl_t;

  typedef struct packed {
    cmd_e in_cmd;
    logic few_vertices;
    logic lowest_none;
    logic lowest_zero;
    logic mark_end;
    logic path_end;
    logic bar_end;
    logic j_end;
    logic bar_fail;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[hw/rtl/vgpc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module vgpc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/vgpc_ctrl.sv]
// Controller state machine for the visibility graph property checker.
// Depends on vgpc_pkg; drives the datapath through ctrl_t and reads stat_t.
`default_nettype none

module vgpc_ctrl import vgpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [13:0] {
    StIdle   = 14'h0001,
    StRowRd  = 14'h0002,
    StRowUse = 14'h0004,
    StPath   = 14'h0008,
    StFlRd   = 14'h0010,
    StFlUse  = 14'h0020,
    StFvRd   = 14'h0040,
    StFvUse  = 14'h0080,
    StFlWr   = 14'h0100,
    StBiRd   = 14'h0200,
    StBiUse  = 14'h0400,
    StBjRd   = 14'h0800,
    StBjUse  = 14'h1000,
    StDone   = 14'h2000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          unique case (stat_i.in_cmd) inside
            CmdWrite, CmdRead: state_d = StRowRd;
            CmdPath:           state_d = StPath;
            default:           state_d = stat_i.few_vertices ? StBiRd : StFlRd;
          endcase
        end
      end
      StRowRd: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = AddrRow;
        state_d       = StRowUse;
      end
      StRowUse: begin
        ctrl_o.rmw = 1'b1;
        state_d    = StDone;
      end
      StPath: begin
        ctrl_o.path_wr = 1'b1;
        if (stat_i.path_end) begin
          state_d = StDone;
        end
      end
      StFlRd: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = AddrLast;
        state_d       = StFlUse;
      end
      StFlUse: begin
        ctrl_o.last_use = 1'b1;
        state_d = (stat_i.lowest_none || stat_i.lowest_zero) ? StBiRd : StFvRd;
      end
      StFvRd: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = AddrI;
        state_d       = StFvUse;
      end
      StFvUse: begin
        ctrl_o.mark_use = 1'b1;
        state_d = stat_i.mark_end ? StFlWr : StFvRd;
      end
      StFlWr: begin
        ctrl_o.last_wr = 1'b1;
        state_d        = StBiRd;
      end
      StBiRd: begin
        if (stat_i.bar_end) begin
          state_d = StDone;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = AddrI;
          state_d       = StBiUse;
        end
      end
      StBiUse: begin
        ctrl_o.rowi_use = 1'b1;
        state_d         = StBjRd;
      end
      StBjRd: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = AddrJ;
        state_d       = StBjUse;
      end
      StBjUse: begin
        ctrl_o.rowj_use = 1'b1;
        if (stat_i.bar_fail) begin
          state_d = StDone;
        end else if (stat_i.j_end) begin
          state_d = StBiRd;
        end else begin
          state_d = StBjRd;
        end
      end
      StDone: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/vgpc_dp.sv]
// Datapath for the visibility graph property checker: row memory, row valid bits,
// walk counters, row buffers and the result register. Depends on vgpc_pkg and vgpc_ram.
`default_nettype none

module vgpc_dp import vgpc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  in_t             in_data_i,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  ctrl_t           ctrl_i,
  output stat_t           stat_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output out_t            out_data_o
);

  function automatic logic [MaxVertices-1:0] mask_between(input logic [IdxW-1:0] lo,
                                                          input logic [IdxW-1:0] hi);
    logic [MaxVertices-1:0] m;
    for (int k = 0; k < MaxVertices; k++) begin
      m[k] = (k > int'(lo)) && (k < int'(hi));
    end
    return m;
  endfunction

  function automatic logic [MaxVertices-1:0] path_row(input logic [IdxW-1:0] v,
                                                      input logic [CntW-1:0] n);
    logic [MaxVertices-1:0] w;
    for (int k = 0; k < MaxVertices; k++) begin
      w[k] = ((k == int'(v) + 1) && (k < int'(n))) ||
             ((k + 1 == int'(v)) && (int'(v) < int'(n)));
    end
    return w;
  endfunction

  logic [CntW-1:0]        vc_q;
  cmd_e                   cmd_q;
  logic [IdxW-1:0]        row_q, col_q;
  logic                   bit_q;
  logic [IdxW-1:0]        i_q, j_q, lowest_q;
  logic [MaxVertices-1:0] rowa_q, mark_q, valid_q;
  logic                   rd_valid_q;
  logic                   legal_q, read_bit_q;
  logic                   out_valid_q;
  out_t                   out_q;

  logic [CntW-1:0]        n_used, n_m1;
  logic [IdxW-1:0]        last;
  logic [IdxW-1:0]        raddr, waddr;
  logic                   we;
  logic [MaxVertices-1:0] wdata, ram_rdata, rd_row, rmw_row;
  logic [IdxW-1:0]        low;
  logic                   low_found, mark_hit, bar_fail;

  assign n_used = (vc_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vc_q;
  assign n_m1   = n_used - CntW'(1);
  assign last   = n_m1[IdxW-1:0];

  always_comb begin
    unique case (ctrl_i.rd_sel)
      AddrRow:  raddr = row_q;
      AddrLast: raddr = last;
      AddrI:    raddr = i_q;
      AddrJ:    raddr = j_q;
      default:  raddr = i_q;
    endcase
  end

  assign rd_row = rd_valid_q ? ram_rdata : '0;

  always_comb begin
    rmw_row        = rd_row;
    rmw_row[col_q] = bit_q;
  end

  always_comb begin
    low       = '0;
    low_found = 1'b0;
    for (int k = MaxVertices - 1; k >= 0; k--) begin
      if (rd_row[k] && (k < int'(last))) begin
        low       = IdxW'(k);
        low_found = 1'b1;
      end
    end
  end

  assign mark_hit = |(rd_row & mask_between(lowest_q, last));
  assign bar_fail = rowa_q[j_q] && !(|(rowa_q & rd_row & mask_between(i_q, j_q)));

  always_comb begin
    we    = 1'b0;
    waddr = i_q;
    wdata = rd_row | (MaxVertices'(1) << last);
    if (ctrl_i.rmw) begin
      we    = (cmd_q == CmdWrite);
      waddr = row_q;
      wdata = rmw_row;
    end else if (ctrl_i.path_wr) begin
      we    = 1'b1;
      wdata = path_row(i_q, n_used);
    end else if (ctrl_i.mark_use) begin
      we    = mark_hit;
    end else if (ctrl_i.last_wr) begin
      we    = 1'b1;
      waddr = last;
      wdata = rowa_q | mark_q;
    end
  end

  vgpc_ram #(
    .Width (MaxVertices),
    .Depth (MaxVertices)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= VertexCountReset;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[raddr];
      end
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl_i.capture || ctrl_i.last_use || ctrl_i.last_wr) begin
        i_q <= '0;
      end else if (ctrl_i.path_wr || ctrl_i.mark_use ||
                   (ctrl_i.rowj_use && stat_o.j_end)) begin
        i_q <= i_q + IdxW'(1);
      end
      if (ctrl_i.rowi_use) begin
        j_q <= i_q + IdxW'(BarGap);
      end else if (ctrl_i.rowj_use) begin
        j_q <= j_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q      <= in_data_i.command;
      row_q      <= in_data_i.row;
      col_q      <= in_data_i.column;
      bit_q      <= in_data_i.bit_value;
      legal_q    <= 1'b1;
      read_bit_q <= 1'b0;
      mark_q     <= '0;
    end
    if (ctrl_i.rmw && (cmd_q == CmdRead)) begin
      read_bit_q <= rd_row[col_q];
    end
    if (ctrl_i.last_use) begin
      rowa_q   <= rd_row;
      lowest_q <= low;
    end
    if (ctrl_i.mark_use && mark_hit) begin
      mark_q[i_q] <= 1'b1;
    end
    if (ctrl_i.rowi_use) begin
      rowa_q <= rd_row;
    end
    if (ctrl_i.rowj_use && bar_fail) begin
      legal_q <= 1'b0;
    end
    if (ctrl_i.out_load) begin
      out_q.read_bit <= read_bit_q;
      out_q.bar_ok   <= (cmd_q == CmdFix) && legal_q;
    end
  end

  always_comb begin
    stat_o.in_cmd       = in_data_i.command;
    stat_o.few_vertices = (n_used < CntW'(2));
    stat_o.lowest_none  = !low_found;
    stat_o.lowest_zero  = (low == '0);
    stat_o.mark_end     = ((i_q + IdxW'(1)) == lowest_q);
    stat_o.path_end     = (i_q == IdxW'(MaxVertices - 1));
    stat_o.bar_end      = (({1'b0, i_q} + CntW'(BarGap)) >= n_used);
    stat_o.j_end        = (({1'b0, j_q} + CntW'(1)) == n_used);
    stat_o.bar_fail     = bar_fail;
    stat_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hw/rtl/visibility_graph_property_checker_unit.sv]
// Top level of the visibility graph property checker.
// Depends on vgpc_pkg, vgpc_ctrl and vgpc_dp (which holds vgpc_ram).
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   in       | in_valid_i / in_ready_o | in_data_i  (command,row,column,bit_value)
//   out      | out_valid_o/out_ready_i | out_data_o (read_bit, bar_ok)
//   cfg      | cfg_we_i                | cfg_wdata_i (vertex_count)
//
// One item at a time; all matrix traffic goes through one row read and one row write
// port. Set path writes one row per cycle.
// Fix-and-check: the bar scan stops at the first failing edge.
// Reset clears the matrix at once through per-row valid bits; no clearing pass.
// The next item is taken while a result waits in the output register.
`default_nettype none

module visibility_graph_property_checker_unit import vgpc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_t            out_data_o,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i
);

  ctrl_t ctrl;
  stat_t stat;

  vgpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  vgpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_capture_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.capture == (in_valid_i && in_ready_o))
    else $error("capture without input transfer");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten");

  a_one_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.rmw, ctrl.path_wr, ctrl.mark_use, ctrl.last_wr}))
    else $error("several row write sources active");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.read_bit && out_data_o.bar_ok))
    else $error("read bit and legal flag both set");

  a_load_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |=> out_valid_o)
    else $error("loaded result not shown");
`endif

endmodule

`default_nettype wire
